// ===== hdl/sm4_pkg.sv =====
`default_nettype none
package sm4_pkg;
	localparam int unsigned Rounds = 32;
	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;
	localparam logic [31:0] CK_START = 32'h00070e15;
	localparam logic [7:0] CK_STEP = 8'd28;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
	} words_t;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] v);
		tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
		rol = (v << n) | (v >> (32 - n));
	endfunction

	// Add the CK step to each byte independently
	function automatic logic [31:0] ck_next(input logic [31:0] c);
		ck_next = {c[31:24] + CK_STEP, c[23:16] + CK_STEP, c[15:8] + CK_STEP,
			c[7:0] + CK_STEP};
	endfunction
endpackage
`default_nettype wire

// ===== hdl/sm4_word_if.sv =====
`default_nettype none
interface sm4_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] high;
	logic [63:0] low;
	modport source (output valid, output high, output low, input ready);
	modport sink (input valid, input high, input low, output ready);
endinterface
`default_nettype wire

// ===== hdl/sm4_cell.sv =====
`default_nettype none
// One round: key schedule and data round side by side, registered.
module sm4_cell
	import sm4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire words_t      key_in,
	input  wire logic [31:0] ck_in,
	input  wire words_t      dat_in,
	output logic             vld_out,
	output words_t           key_out,
	output logic [31:0]      ck_out,
	output words_t           dat_out
);
	logic [31:0] kb, rk, xb, nx;

	always_comb begin
		kb = tau(key_in.w1 ^ key_in.w2 ^ key_in.w3 ^ ck_in);
		rk = key_in.w0 ^ kb ^ rol(kb, 13) ^ rol(kb, 23);
		xb = tau(dat_in.w1 ^ dat_in.w2 ^ dat_in.w3 ^ rk);
		nx = dat_in.w0 ^ xb ^ rol(xb, 2) ^ rol(xb, 10) ^ rol(xb, 18) ^ rol(xb, 24);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_out <= '{key_in.w1, key_in.w2, key_in.w3, rk};
			ck_out  <= ck_next(ck_in);
			dat_out <= '{dat_in.w1, dat_in.w2, dat_in.w3, nx};
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sm4_block_encrypt_top.sv =====
`default_nettype none
// SM4 block encryption engine, ECB style, one 128-bit word per cycle unless stalled.
//
// Channels: blk_in (sink) takes a plaintext word as high/low 64-bit halves,
// big-endian; ct_out (source) gives the ciphertext word the same way.
// Configuration: cfg_we writes cfg_data to key_high (index 0) or key_low
// (index 1), the only two indexes. Write only while the engine is idle.
//
// Each accepted word passes through the 32 round cells on its way to ct_out.
// Throughput: one word per cycle while not stalled, set by the chain of
// round cells, each doing one key-schedule round and one data round and
// handing both on. The round key travels with its word, so the key is
// latched per word.
// Stall: the whole chain holds while the output word is valid and not taken;
// ready then falls on the input. Reset clears the valid bits and the key to
// zero.
module sm4_block_encrypt_top
	import sm4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	sm4_word_if.sink         blk_in,
	sm4_word_if.source       ct_out
);
	logic [63:0] key_high_q, key_low_q;
	logic        vld   [Rounds+1];
	words_t      key   [Rounds+1];
	logic [31:0] ck    [Rounds+1];
	words_t      dat   [Rounds+1];
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the chain unless the last stage holds an untaken word
	assign en = !vld[Rounds] || ct_out.ready;
	assign blk_in.ready = en;

	assign vld[0] = blk_in.valid;
	assign key[0] = '{key_high_q[63:32] ^ FK0, key_high_q[31:0] ^ FK1,
		key_low_q[63:32] ^ FK2, key_low_q[31:0] ^ FK3};
	assign ck[0]  = CK_START;
	assign dat[0] = '{blk_in.high[63:32], blk_in.high[31:0],
		blk_in.low[63:32], blk_in.low[31:0]};

	for (genvar g = 0; g < Rounds; g++) begin : g_round
		sm4_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (vld[g]),
			.key_in  (key[g]),
			.ck_in   (ck[g]),
			.dat_in  (dat[g]),
			.vld_out (vld[g+1]),
			.key_out (key[g+1]),
			.ck_out  (ck[g+1]),
			.dat_out (dat[g+1])
		);
	end

	// Reverse the word order on the way out
	assign ct_out.valid = vld[Rounds];
	assign ct_out.high  = {dat[Rounds].w3, dat[Rounds].w2};
	assign ct_out.low   = {dat[Rounds].w1, dat[Rounds].w0};
endmodule
`default_nettype wire

// ===== hdl/sm4_block_encrypt_chk.sv =====
`default_nettype none
module sm4_block_encrypt_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready) else $error("ready while stalled");
	a_free_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("not ready with free output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("output word dropped");
endmodule

bind sm4_block_encrypt_top sm4_block_encrypt_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (blk_in.valid),
	.in_ready  (blk_in.ready),
	.out_valid (ct_out.valid),
	.out_ready (ct_out.ready)
);
`default_nettype wire

// ===== sim/sm4_block_encrypt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sm4_block_encrypt_checker
	import sm4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [63:0] in_high,
	input  wire logic [63:0] in_low,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] out_high,
	input  wire logic [63:0] out_low,
	output int               errors,
	output int               pending
);
	logic [63:0] key_hi_q, key_lo_q;
	logic [127:0] cipher_q [$];

	function automatic logic [31:0] sub_bytes(input logic [31:0] v);
		return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [63:0] kh, input logic [63:0] kl,
			input logic [63:0] ph, input logic [63:0] pl);
		logic [31:0] k [4];
		logic [31:0] x [4];
		logic [31:0] rk [32];
		logic [7:0] cb [4];
		logic [31:0] b, nw;
		k[0] = kh[63:32] ^ FK0;
		k[1] = kh[31:0] ^ FK1;
		k[2] = kl[63:32] ^ FK2;
		k[3] = kl[31:0] ^ FK3;
		cb = '{8'h00, 8'h07, 8'h0e, 8'h15};
		for (int i = 0; i < 32; i++) begin
			b = sub_bytes(k[1] ^ k[2] ^ k[3] ^ {cb[0], cb[1], cb[2], cb[3]});
			nw = k[0] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
			rk[i] = nw;
			k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nw;
			for (int j = 0; j < 4; j++) cb[j] = cb[j] + 8'd28;
		end
		x[0] = ph[63:32]; x[1] = ph[31:0]; x[2] = pl[63:32]; x[3] = pl[31:0];
		for (int i = 0; i < 32; i++) begin
			b = sub_bytes(x[1] ^ x[2] ^ x[3] ^ rk[i]);
			nw = x[0] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
			x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nw;
		end
		return {x[3], x[2], x[1], x[0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		int           miss;
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			cipher_q.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			miss = 0;
			if (in_valid && in_ready)
				cipher_q.push_back(encrypt_block(key_hi_q, key_lo_q, in_high, in_low));
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected ciphertext word %h_%h", out_high, out_low);
					miss = miss + 1;
				end else begin
					want = cipher_q.pop_front();
					if (out_high !== want[127:64]) begin
						$error("cipher_high expected %h actual %h", want[127:64], out_high);
						miss = miss + 1;
					end
					if (out_low !== want[63:0]) begin
						$error("cipher_low expected %h actual %h", want[63:0], out_low);
						miss = miss + 1;
					end
				end
			end
			errors <= errors + miss;
			pending <= cipher_q.size();
			if (cfg_we) begin
				if (cfg_index == REG_KEY_HIGH) key_hi_q <= cfg_data;
				else if (cfg_index == REG_KEY_LOW) key_lo_q <= cfg_data;
			end
		end
	end
endmodule
`default_nettype wire

// ===== sim/sm4_block_encrypt_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sm4_block_encrypt_top_tb;
	import sm4_pkg::*;

	localparam int Latency = 32;
	localparam int CycleLimit = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_KEY_HIGH;
	logic [63:0] cfg_data = '0;
	int          errors, pending;
	int          cycles = 0;
	int          stall_mode = 0;

	sm4_word_if blk_in ();
	sm4_word_if ct_out ();

	sm4_block_encrypt_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .blk_in(blk_in.sink), .ct_out(ct_out.source)
	);

	sm4_block_encrypt_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(blk_in.valid), .in_ready(blk_in.ready),
		.in_high(blk_in.high), .in_low(blk_in.low),
		.out_valid(ct_out.valid), .out_ready(ct_out.ready),
		.out_high(ct_out.high), .out_low(ct_out.low),
		.errors(errors), .pending(pending)
	);

	always #10 clk = ~clk;

	// Watchdog: a hung chain ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("sm4_block_encrypt_top_tb failed");
			$finish;
		end
	end

	// Receiver back-pressure; pattern chosen per phase by stall_mode
	initial ct_out.ready = 1'b0;
	always @(negedge clk) begin
		case (stall_mode)
			0: ct_out.ready <= 1'b1;
			1: ct_out.ready <= ($urandom_range(0, 3) != 0);
			2: ct_out.ready <= ($urandom_range(0, 3) == 0);
			default: ct_out.ready <= (cycles % 7 < 4);
		endcase
	end

	// Hold a word on the input until it is taken; leave valid high on return
	task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
		blk_in.valid <= 1'b1;
		blk_in.high <= hi;
		blk_in.low <= lo;
		@(posedge clk);
		while (!blk_in.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drop_valid();
		blk_in.valid <= 1'b0;
	endtask

	// Drain every outstanding word, then let the chain settle
	task automatic drain();
		drop_valid();
		while (pending != 0) @(negedge clk);
		repeat (Latency + 4) @(negedge clk);
	endtask

	task automatic write_key(input reg_index_t idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Random burst traffic: bursts of back-to-back words split by gaps
	task automatic random_traffic(input int count);
		int sent, burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_word(rand64(), rand64());
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				drop_valid();
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		drop_valid();
	endtask

	initial begin
		blk_in.valid = 1'b0;
		blk_in.high = '0;
		blk_in.low = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: all-zero key left from reset, field extremes, walking ones
		send_word('0, '0);
		send_word('1, '1);
		send_word('0, '1);
		send_word('1, '0);
		send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_word(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		for (int i = 0; i < 8; i++)
			send_word(64'h1 << (i * 8 + 3), 64'h8000000000000000 >> (i * 8 + 1));
		drain();

		// Standard test key, then the all-ones key
		write_key(REG_KEY_HIGH, 64'h0123456789abcdef);
		write_key(REG_KEY_LOW, 64'hfedcba9876543210);
		send_word(64'h0123456789abcdef, 64'hfedcba9876543210);
		send_word('0, '1);
		drain();
		write_key(REG_KEY_HIGH, '1);
		write_key(REG_KEY_LOW, '1);
		send_word('0, '0);
		send_word('1, '1);
		drain();

		// Random phases under random keys (all-zero in the last) and rotating stall patterns
		for (int phase = 0; phase < 6; phase++) begin
			stall_mode = phase % 4;
			write_key(REG_KEY_HIGH, (phase == 5) ? 64'h0 : rand64());
			write_key(REG_KEY_LOW, (phase == 5) ? 64'h0 : rand64());
			random_traffic(150);
			drain();
		end

		if (errors == 0) begin
			$display("sm4_block_encrypt_top_tb passed");
		end else begin
			$display("sm4_block_encrypt_top_tb failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
